// ===== src/rftg_pkg.sv =====
`timescale 1ns / 1ps
// rftg_pkg: constants, codes and shared types of the file-transfer group generator
// no dependencies; used by every other file of the block

package rftg_pkg;

  localparam int FILE_BYTES     = 163840;
  localparam int CRC_WORDS      = 512;
  localparam int SCHEDULE_SLOTS = 50;

  localparam int LANES     = 5;
  localparam int LANE_W    = 3;
  localparam int KIND_W    = 2;
  localparam int ADDR_W    = 18;
  localparam int DATA_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int BLOCK_W   = 16;
  localparam int SLOT_W    = 6;
  localparam int SEG_W     = 15;
  localparam int COUNT_W   = SEG_W + 1;
  localparam int CRC_PTR_W = 9;
  localparam int CRC_CNT_W = 10;
  localparam int VER_W     = 7;
  localparam int VER_MAX   = 64;

  localparam int PIPE_W  = 4;
  localparam int APPID_W = 16;
  localparam int MODE_W  = 3;
  localparam int IDENT_W = 6;
  localparam int LEN_W   = 18;

  localparam int ROWS       = (FILE_BYTES + LANES - 1) / LANES;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LAST_LANES = FILE_BYTES - LANES * (ROWS - 1);
  localparam int CRC_AW     = (CRC_WORDS > 1) ? $clog2(CRC_WORDS) : 1;

  // floor(x / 5) as (x * RECIP) >> RECIP_SHIFT, exact for x below FILE_BYTES + LANES
  localparam int RECIP_SHIFT = ADDR_W;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + LANES - 1) / LANES;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = ADDR_W + RECIP_W;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [BLOCK_W-1:0] META_HDR = 16'h8000;
  localparam logic [BLOCK_W-1:0] DATA_HDR = 16'h2000;
  localparam logic [BLOCK_W-1:0] MAP_TAG  = 16'h1000;

  localparam logic [2:0] REG_PIPE  = 3'd0;
  localparam logic [2:0] REG_APPID = 3'd1;
  localparam logic [2:0] REG_CRCEN = 3'd2;
  localparam logic [2:0] REG_MODE  = 3'd3;
  localparam logic [2:0] REG_IDENT = 3'd4;
  localparam logic [2:0] REG_LEN   = 3'd5;
  localparam logic [2:0] REG_CRCN  = 3'd6;

  typedef enum logic [KIND_W-1:0] {
    OP_FILE_WR = 2'd0,
    OP_CRC_WR  = 2'd1,
    OP_REQUEST = 2'd2,
    OP_REPLACE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    GRP_META = 2'd0,
    GRP_MAP  = 2'd1,
    GRP_DATA = 2'd2
  } grp_kind_t;

  typedef struct packed {
    logic [PIPE_W-1:0]    pipe;
    logic [APPID_W-1:0]   app_id;
    logic                 crc_en;
    logic [MODE_W-1:0]    mode;
    logic [IDENT_W-1:0]   ident;
    logic [LEN_W-1:0]     length;
    logic [CRC_CNT_W-1:0] crc_count;
    logic [COUNT_W-1:0]   seg_count;
  } cfg_t;

  typedef struct packed {
    logic                wr_file;
    logic                wr_crc;
    logic                req;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   wbyte;
    logic [DATA_W-1:0]   wword;
    logic [ROW_W-1:0]    row;
    logic [CRC_AW-1:0]   crc_idx;
    logic [LANES-1:0]    keep;
    grp_kind_t           gkind;
    logic [BLOCK_W-1:0]  a;
    logic [BLOCK_W-1:0]  b;
    logic [BLOCK_W-1:0]  c;
    logic [BLOCK_W-1:0]  d;
  } stage_t;

endpackage

// ===== src/rftg_if.sv =====
`timescale 1ns / 1ps
// rftg_cmd_if and rftg_grp_if: valid/ready channels for command words and group words
// depends on rftg_pkg for field widths

interface rftg_cmd_if
  import rftg_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;

  modport source (output valid, output kind, output address, output data, input ready);
  modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

interface rftg_grp_if
  import rftg_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] block_a;
  logic [BLOCK_W-1:0] block_b;
  logic [BLOCK_W-1:0] block_c;
  logic [BLOCK_W-1:0] block_d;
  logic [1:0]         group_kind;

  modport source (output valid, output block_a, output block_b, output block_c,
                  output block_d, output group_kind, input ready);
  modport sink   (input valid, input block_a, input block_b, input block_c,
                  input block_d, input group_kind, output ready);
endinterface

// ===== src/rds2_file_transfer_group_gen.sv =====
`timescale 1ns / 1ps
// RDS2 file-transfer group generator: takes one command word per cycle (byte write,
// crc word write, group request or file replaced) and returns one four-block group
// word per group request, passed through the input, memory stage and output registers.
// The file bytes sit in five byte-wide banks, so one segment of five bytes comes out
// of a single read of the segment row; the crc words sit in a second memory read once
// per mapping group. A register stage on each side of the memory read lets a new
// command in every cycle while the output is taken; while a finished group waits on
// the output, up to two more command words are taken and then the input stalls until
// the group leaves. The memories are not cleared at reset: reads of entries never
// written return undefined bytes. Configuration goes through the APB port; the user
// writes it while the block is idle, which the block itself does not enforce.
// Depends on rftg_pkg, rftg_if, rftg_regs, rftg_sched and rftg_store.

module rds2_file_transfer_group_gen
  import rftg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  rftg_cmd_if.sink           cmd,
  rftg_grp_if.source         grp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t   cfg;
  logic   stage_valid;
  logic   stage_ready;
  stage_t stage;

  rftg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rftg_sched u_sched (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage       (stage)
  );

  rftg_store u_store (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage       (stage),
    .grp         (grp)
  );

endmodule

// ===== src/rftg_regs.sv =====
`timescale 1ns / 1ps
// rftg_regs: APB configuration registers and the derived segment count
// depends on rftg_pkg

module rftg_regs
  import rftg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [PIPE_W-1:0]    pipe;
  logic [APPID_W-1:0]   app_id;
  logic                 crc_en;
  logic [MODE_W-1:0]    mode;
  logic [IDENT_W-1:0]   ident;
  logic [LEN_W-1:0]     length;
  logic [CRC_CNT_W-1:0] crc_words;
  logic [COUNT_W-1:0]   seg_count;

  logic [2:0]          idx;
  logic                wr;
  logic [ADDR_W-1:0]   len_clamp;
  logic [ADDR_W-1:0]   len_round;
  logic [PROD_W-1:0]   seg_prod;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe      <= '0;
      app_id    <= '0;
      crc_en    <= 1'b0;
      mode      <= '0;
      ident     <= '0;
      length    <= '0;
      crc_words <= CRC_CNT_W'(1);
    end else if (wr) begin
      case (idx)
        REG_PIPE:  pipe      <= pwdata[PIPE_W-1:0];
        REG_APPID: app_id    <= pwdata[APPID_W-1:0];
        REG_CRCEN: crc_en    <= pwdata[0];
        REG_MODE:  mode      <= pwdata[MODE_W-1:0];
        REG_IDENT: ident     <= pwdata[IDENT_W-1:0];
        REG_LEN:   length    <= pwdata[LEN_W-1:0];
        REG_CRCN:  crc_words <= pwdata[CRC_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // segments = ceil(min(length, file size) / 5)
  assign len_clamp = (length > ADDR_W'(FILE_BYTES)) ? ADDR_W'(FILE_BYTES) : length;
  assign len_round = len_clamp + ADDR_W'(LANES - 1);
  assign seg_prod  = PROD_W'(len_round) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
    end else begin
      seg_count <= seg_prod[RECIP_SHIFT +: COUNT_W];
    end
  end

  always_comb begin
    case (idx)
      REG_PIPE:  prdata = PDATA_W'(pipe);
      REG_APPID: prdata = PDATA_W'(app_id);
      REG_CRCEN: prdata = PDATA_W'(crc_en);
      REG_MODE:  prdata = PDATA_W'(mode);
      REG_IDENT: prdata = PDATA_W'(ident);
      REG_LEN:   prdata = PDATA_W'(length);
      REG_CRCN:  prdata = PDATA_W'(crc_words);
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pipe      = pipe;
    cfg.app_id    = app_id;
    cfg.crc_en    = crc_en;
    cfg.mode      = mode;
    cfg.ident     = ident;
    cfg.length    = length;
    cfg.crc_count = (crc_words > CRC_CNT_W'(CRC_WORDS)) ? CRC_CNT_W'(CRC_WORDS) : crc_words;
    cfg.seg_count = seg_count;
  end

endmodule

// ===== src/rftg_sched.sv =====
`timescale 1ns / 1ps
// rftg_sched: input register, schedule slot, pointers and group header build
// depends on rftg_pkg and rftg_cmd_if

module rftg_sched
  import rftg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rftg_cmd_if.sink    cmd,
  input  cfg_t        cfg,
  output logic        stage_valid,
  input  logic        stage_ready,
  output stage_t      stage
);

  logic              s1_valid;
  op_t               s1_kind;
  logic [ADDR_W-1:0] s1_addr;
  logic [DATA_W-1:0] s1_data;

  logic [SLOT_W-1:0]    slot;
  logic [SEG_W-1:0]     seg;
  logic [CRC_PTR_W-1:0] crc_ptr;
  logic                 toggle;
  logic [VER_W-1:0]     version;

  logic [SLOT_W-1:0]    slot_next;
  logic [SEG_W-1:0]     seg_next;
  logic [CRC_PTR_W-1:0] crc_ptr_next;
  logic [VER_W-1:0]     version_next;

  logic [SLOT_W:0]      slot_inc;
  logic [COUNT_W-1:0]   seg_inc;
  logic [CRC_CNT_W-1:0] crc_inc;
  logic [VER_W-1:0]     ver_inc;
  logic [PROD_W-1:0]    row_prod;
  logic [ROW_W-1:0]     wr_row;
  logic [ROW_W-1:0]     rd_row;
  logic                 fire;
  grp_kind_t            gkind;

  assign cmd.ready = !s1_valid || stage_ready;
  assign fire      = s1_valid && stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_kind <= op_t'(cmd.kind);
      s1_addr <= cmd.address;
      s1_data <= cmd.data;
    end
  end

  always_comb begin
    case (slot)
      SLOT_W'(0), SLOT_W'(2): gkind = GRP_META;
      SLOT_W'(1), SLOT_W'(3): gkind = GRP_MAP;
      default:                gkind = GRP_DATA;
    endcase
  end

  assign slot_inc  = {1'b0, slot} + (SLOT_W+1)'(1);
  assign slot_next = (slot_inc >= (SLOT_W+1)'(SCHEDULE_SLOTS)) ? '0 : slot_inc[SLOT_W-1:0];
  assign seg_inc   = {1'b0, seg} + COUNT_W'(1);
  assign seg_next  = (seg_inc >= cfg.seg_count) ? '0 : seg_inc[SEG_W-1:0];
  assign crc_inc   = CRC_CNT_W'(crc_ptr) + CRC_CNT_W'(1);
  assign crc_ptr_next = (crc_inc >= cfg.crc_count) ? '0 : crc_inc[CRC_PTR_W-1:0];
  assign ver_inc   = version + VER_W'(1);
  assign version_next = (ver_inc > VER_W'(VER_MAX)) ? '0 : ver_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      seg     <= '0;
      crc_ptr <= '0;
      toggle  <= 1'b0;
      version <= '0;
    end else if (fire) begin
      case (s1_kind)
        OP_REPLACE: begin
          version <= version_next;
          toggle  <= !toggle;
          seg     <= '0;
        end
        OP_REQUEST: begin
          slot <= slot_next;
          if (gkind == GRP_MAP) begin
            crc_ptr <= crc_ptr_next;
          end else if (gkind == GRP_DATA) begin
            seg <= seg_next;
          end
        end
        default: ;
      endcase
    end
  end

  // byte address to bank row: address / 5
  assign row_prod = PROD_W'(s1_addr) * PROD_W'(RECIP);
  assign wr_row   = row_prod[RECIP_SHIFT +: ROW_W];
  assign rd_row   = seg[ROW_W-1:0];

  assign stage_valid = s1_valid;

  always_comb begin
    stage.wr_file = (s1_kind == OP_FILE_WR) && (s1_addr < ADDR_W'(FILE_BYTES));
    stage.wr_crc  = (s1_kind == OP_CRC_WR) && (s1_addr < ADDR_W'(CRC_WORDS));
    stage.req     = (s1_kind == OP_REQUEST);
    stage.addr    = s1_addr;
    stage.wbyte   = s1_data[BYTE_W-1:0];
    stage.wword   = s1_data;
    stage.row     = stage.req ? rd_row : wr_row;
    stage.crc_idx = stage.req ? crc_ptr[CRC_AW-1:0] : s1_addr[CRC_AW-1:0];
    for (int l = 0; l < LANES; l++) begin
      stage.keep[l] = !((rd_row == ROW_W'(ROWS - 1)) && (l >= LAST_LANES));
    end
    stage.gkind = gkind;
    case (gkind)
      GRP_META: begin
        stage.a = META_HDR | BLOCK_W'(cfg.pipe);
        stage.b = cfg.app_id;
        stage.c = {4'h0, cfg.crc_en, version[2:0], cfg.ident, cfg.length[17:16]};
        stage.d = cfg.length[15:0];
      end
      GRP_MAP: begin
        stage.a = META_HDR | BLOCK_W'(cfg.pipe);
        stage.b = cfg.app_id;
        stage.c = MAP_TAG | {4'h0, cfg.mode, crc_ptr};
        stage.d = '0;
      end
      default: begin
        stage.a = DATA_HDR | {4'h0, cfg.pipe, toggle, seg[14:8]};
        stage.b = {seg[7:0], 8'h00};
        stage.c = '0;
        stage.d = '0;
      end
    endcase
  end

endmodule

// ===== src/rftg_store.sv =====
`timescale 1ns / 1ps
// rftg_store: file and crc memories, memory stage register and output register
// depends on rftg_pkg and rftg_grp_if

module rftg_store
  import rftg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        stage_valid,
  output logic        stage_ready,
  input  stage_t      stage,
  rftg_grp_if.source  grp
);

  logic               s2_valid;
  stage_t             s2;
  logic               s3_valid;
  grp_kind_t          s3_gkind;
  logic [BLOCK_W-1:0] s3_a;
  logic [BLOCK_W-1:0] s3_b;
  logic [BLOCK_W-1:0] s3_c;
  logic [BLOCK_W-1:0] s3_d;
  logic [LANES-1:0]   s3_keep;

  logic                          s3_ready;
  logic                          s2_fire;
  logic [ADDR_W-1:0]             lane_off;
  logic [LANE_W-1:0]             bank;
  logic [LANES-1:0][BYTE_W-1:0]  lane_b;
  logic [DATA_W-1:0]             crc_q;
  logic [DATA_W-1:0]             crc_mem [CRC_WORDS];

  assign s3_ready    = !s3_valid || grp.ready;
  assign stage_ready = !s2_valid || s3_ready;
  assign s2_fire     = s2_valid && s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (stage_ready) begin
      s2_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && stage_ready) begin
      s2 <= stage;
    end
  end

  // bank = address - 5 * row
  assign lane_off = s2.addr - ADDR_W'({s2.row, 2'b00}) - ADDR_W'(s2.row);
  assign bank     = lane_off[LANE_W-1:0];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [BYTE_W-1:0] mem [ROWS];
    logic [BYTE_W-1:0] q;

    always_ff @(posedge clk) begin
      if (s2_fire && s2.wr_file && (bank == LANE_W'(l))) begin
        mem[s2.row] <= s2.wbyte;
      end
      if (s2_fire && s2.req && (s2.gkind == GRP_DATA)) begin
        q <= mem[s2.row];
      end
    end

    assign lane_b[l] = s3_keep[l] ? q : '0;
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2.wr_crc) begin
      crc_mem[s2.crc_idx] <= s2.wword;
    end
    if (s2_fire && s2.req && (s2.gkind == GRP_MAP)) begin
      crc_q <= crc_mem[s2.crc_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid && s2.req;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      s3_gkind <= s2.gkind;
      s3_a     <= s2.a;
      s3_b     <= s2.b;
      s3_c     <= s2.c;
      s3_d     <= s2.d;
      s3_keep  <= s2.keep;
    end
  end

  assign grp.valid      = s3_valid;
  assign grp.group_kind = s3_gkind;
  assign grp.block_a    = s3_a;

  always_comb begin
    case (s3_gkind)
      GRP_META: begin
        grp.block_b = s3_b;
        grp.block_c = s3_c;
        grp.block_d = s3_d;
      end
      GRP_MAP: begin
        grp.block_b = s3_b;
        grp.block_c = s3_c;
        grp.block_d = crc_q;
      end
      default: begin
        grp.block_b = {s3_b[15:8], lane_b[0]};
        grp.block_c = {lane_b[1], lane_b[2]};
        grp.block_d = {lane_b[3], lane_b[4]};
      end
    endcase
  end

endmodule
